>>> design/bps_pkg.sv
// ---------------------------------------------------------------------------
// Byte pattern search package
// Shared constants, register indexes and the pattern configuration bundle.
// ---------------------------------------------------------------------------
package bps_pkg;

   localparam int MAX_PATTERN         = 32;
   localparam int ADDRESS_WIDTH       = 32;
   localparam int DATA_WIDTH          = 8;
   localparam int CSR_DATA_WIDTH      = 64;
   localparam int CSR_INDEX_WIDTH     = 3;
   localparam int LENGTH_WIDTH        = 6;
   localparam int PATTERN_WORDS       = 4;
   localparam int PATTERN_BYTES       = 32;
   localparam int PATTERN_INDEX_WIDTH = 5;
   localparam int POS_WIDTH           = PATTERN_INDEX_WIDTH + 1;
   localparam int RUN_WIDTH           = $clog2(MAX_PATTERN + 1);

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_PATTERN_LO     = 3'd0,
      CSR_PATTERN_MID    = 3'd1,
      CSR_PATTERN_HIGH   = 3'd2,
      CSR_PATTERN_TOP    = 3'd3,
      CSR_PATTERN_LENGTH = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [MAX_PATTERN-1:0][DATA_WIDTH-1:0] aligned;
      logic [MAX_PATTERN-1:0]                 care;
      logic [RUN_WIDTH-1:0]                   length;
   } pattern_cfg_type;

   function automatic logic [RUN_WIDTH-1:0] effective_length(
      input logic [LENGTH_WIDTH-1:0] raw
   );
      logic [RUN_WIDTH-1:0] len;
      if (raw == '0) begin
         len = RUN_WIDTH'(1);
      end else if (raw > LENGTH_WIDTH'(MAX_PATTERN)) begin
         len = RUN_WIDTH'(MAX_PATTERN);
      end else begin
         len = RUN_WIDTH'(raw);
      end
      return len;
   endfunction

endpackage

>>> design/byte_pattern_search_core.sv
// ---------------------------------------------------------------------------
// Byte pattern search core
// Leftmost non-overlapping search of a byte stream for a configured pattern.
//
//   port group | direction | contents
//   req_*      | in        | data byte, address, segment start, end of data
//   rsp_*      | out       | match flag, match start address, search finished
//   csr_*      | in        | pattern words 0..3, pattern length (index 4)
//
// One request per cycle while req_stall is low; a request is registered,
// compared against the byte window and, on a match or at end of data, its
// response lands in the output register.
// Reset is synchronous; it clears the window, run counter and pattern.
// A stalled response holds the pipe; the input register still takes a request
// while the output register waits, then asserts req_stall.
// ---------------------------------------------------------------------------
module byte_pattern_search_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [bps_pkg::DATA_WIDTH-1:0]      req_data_byte,
   input  logic [bps_pkg::ADDRESS_WIDTH-1:0]   req_byte_address,
   input  logic                                req_segment_start,
   input  logic                                req_end_of_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_match_valid,
   output logic [bps_pkg::ADDRESS_WIDTH-1:0]   rsp_match_address,
   output logic                                rsp_search_finished,
   input  logic                                csr_write_enable,
   input  logic [bps_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [bps_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   bps_pkg::pattern_cfg_type pattern_cfg;

   logic                               in_valid_ff, in_valid_in;
   logic [bps_pkg::DATA_WIDTH-1:0]     in_data_ff;
   logic [bps_pkg::ADDRESS_WIDTH-1:0]  in_address_ff;
   logic                               in_segment_ff;
   logic                               in_last_ff;

   logic                               out_valid_ff, out_valid_in;
   logic                               out_match_ff;
   logic [bps_pkg::ADDRESS_WIDTH-1:0]  out_address_ff;
   logic                               out_finished_ff;

   logic advance;
   logic req_accept;
   logic hit;
   logic [bps_pkg::ADDRESS_WIDTH-1:0] start_address;

   bps_config u_config (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .pattern_cfg      (pattern_cfg)
   );

   bps_match u_match (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .data_byte     (in_data_ff),
      .segment_start (in_segment_ff),
      .end_of_data   (in_last_ff),
      .pattern_cfg   (pattern_cfg),
      .hit           (hit)
   );

   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign out_valid_in = advance ? (hit || in_last_ff) : (out_valid_ff && rsp_stall);

   assign start_address = in_address_ff
      - bps_pkg::ADDRESS_WIDTH'(pattern_cfg.length - bps_pkg::RUN_WIDTH'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff    <= req_data_byte;
         in_address_ff <= req_byte_address;
         in_segment_ff <= req_segment_start;
         in_last_ff    <= req_end_of_data;
      end
      if (advance) begin
         out_match_ff    <= hit;
         out_address_ff  <= hit ? start_address : '0;
         out_finished_ff <= in_last_ff;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_match_valid     = out_match_ff;
   assign rsp_match_address   = out_address_ff;
   assign rsp_search_finished = out_finished_ff;

endmodule

>>> design/bps_config.sv
// ---------------------------------------------------------------------------
// Byte pattern search configuration
// Pattern and length registers; presents the pattern aligned to the window.
// ---------------------------------------------------------------------------
module bps_config (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [bps_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [bps_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data,
   output bps_pkg::pattern_cfg_type             pattern_cfg
);

   logic [bps_pkg::PATTERN_WORDS-1:0][bps_pkg::CSR_DATA_WIDTH-1:0] pattern_ff, pattern_in;
   logic [bps_pkg::LENGTH_WIDTH-1:0] length_ff, length_in;
   logic [bps_pkg::PATTERN_BYTES-1:0][bps_pkg::DATA_WIDTH-1:0] pattern_bytes;
   logic [bps_pkg::RUN_WIDTH-1:0] length_eff;
   logic [bps_pkg::POS_WIDTH-1:0] pos;

   always_comb begin
      pattern_in = pattern_ff;
      length_in  = length_ff;
      if (csr_write_enable) begin
         unique case (bps_pkg::csr_index_type'(csr_index))
            bps_pkg::CSR_PATTERN_LO:     pattern_in[0] = csr_write_data;
            bps_pkg::CSR_PATTERN_MID:    pattern_in[1] = csr_write_data;
            bps_pkg::CSR_PATTERN_HIGH:   pattern_in[2] = csr_write_data;
            bps_pkg::CSR_PATTERN_TOP:    pattern_in[3] = csr_write_data;
            bps_pkg::CSR_PATTERN_LENGTH:
               length_in = csr_write_data[bps_pkg::LENGTH_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= bps_pkg::LENGTH_WIDTH'(1);
      end else begin
         pattern_ff <= pattern_in;
         length_ff  <= length_in;
      end
   end

   assign pattern_bytes = pattern_ff;
   assign length_eff    = bps_pkg::effective_length(length_ff);

   // window entry j (0 = newest) must equal pattern byte length-1-j
   always_comb begin
      pattern_cfg.length = length_eff;
      pos = '0;
      for (int j = 0; j < bps_pkg::MAX_PATTERN; j++) begin
         pos = bps_pkg::POS_WIDTH'(length_eff) - bps_pkg::POS_WIDTH'(j)
               - bps_pkg::POS_WIDTH'(1);
         pattern_cfg.care[j] = (bps_pkg::POS_WIDTH'(j) < bps_pkg::POS_WIDTH'(length_eff));
         pattern_cfg.aligned[j] = pattern_cfg.care[j] ?
            pattern_bytes[pos[bps_pkg::PATTERN_INDEX_WIDTH-1:0]] : '0;
      end
   end

endmodule

>>> design/bps_match.sv
// ---------------------------------------------------------------------------
// Byte pattern search matcher
// Byte window and contiguous run counter; compares the window to the pattern.
// ---------------------------------------------------------------------------
module bps_match (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic [bps_pkg::DATA_WIDTH-1:0]     data_byte,
   input  logic                               segment_start,
   input  logic                               end_of_data,
   input  bps_pkg::pattern_cfg_type           pattern_cfg,
   output logic                               hit
);

   logic [bps_pkg::MAX_PATTERN-1:0][bps_pkg::DATA_WIDTH-1:0] window_ff, window_in;
   logic [bps_pkg::RUN_WIDTH-1:0] run_ff, run_in, run_next;
   logic [bps_pkg::MAX_PATTERN-1:0] byte_ok;

   assign window_in[0] = data_byte;
   for (genvar j = 1; j < bps_pkg::MAX_PATTERN; j++) begin : g_shift
      assign window_in[j] = window_ff[j-1];
   end

   always_comb begin
      if (segment_start) begin
         run_next = bps_pkg::RUN_WIDTH'(1);
      end else if (run_ff < bps_pkg::RUN_WIDTH'(bps_pkg::MAX_PATTERN)) begin
         run_next = run_ff + bps_pkg::RUN_WIDTH'(1);
      end else begin
         run_next = run_ff;
      end
   end

   always_comb begin
      for (int j = 0; j < bps_pkg::MAX_PATTERN; j++) begin
         byte_ok[j] = !pattern_cfg.care[j] || (window_in[j] == pattern_cfg.aligned[j]);
      end
   end

   assign hit    = (run_next >= pattern_cfg.length) && (&byte_ok);
   assign run_in = (hit || end_of_data) ? '0 : run_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         run_ff    <= '0;
      end else if (advance) begin
         window_ff <= window_in;
         run_ff    <= run_in;
      end
   end

endmodule
